[rtl/core/sparse_polynomial_add_eval_defines.svh]
// Assertion macros shared by the RTL of the sparse polynomial block.
`ifndef SPARSE_POLYNOMIAL_ADD_EVAL_DEFINES_SVH
`define SPARSE_POLYNOMIAL_ADD_EVAL_DEFINES_SVH
// Implication checked at every clock edge outside reset.
`define SPA_ASSERT_IMP(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);
// Next-cycle implication checked outside reset.
`define SPA_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`endif

[rtl/core/spa_pkg.sv]
// Package with constants, command codes and the control interface types.
package spa_pkg;
   localparam int MaxTerms     = 32;
   localparam int FractionBits = 16;
   localparam int IdxW         = $clog2(MaxTerms);
   localparam int CntW         = $clog2(MaxTerms + 1);

   localparam logic [2:0] CMD_LOAD_A = 3'd0;
   localparam logic [2:0] CMD_LOAD_B = 3'd1;
   localparam logic [2:0] CMD_CLEAR  = 3'd2;
   localparam logic [2:0] CMD_EVAL   = 3'd3;
   localparam logic [2:0] CMD_ADD    = 3'd4;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   // Datapath operations selected by the controller.
   localparam logic [3:0] OP_NONE    = 4'd0;
   localparam logic [3:0] OP_LOAD    = 4'd1;
   localparam logic [3:0] OP_CLEAR   = 4'd2;
   localparam logic [3:0] OP_SRD     = 4'd3;  // read pair i, j of a table
   localparam logic [3:0] OP_SCMP    = 4'd4;  // compare, swap if needed
   localparam logic [3:0] OP_ERD     = 4'd5;  // read term of A for evaluate
   localparam logic [3:0] OP_EPW     = 4'd6;  // one power step
   localparam logic [3:0] OP_ETERM   = 4'd7;  // coefficient times power
   localparam logic [3:0] OP_EACC    = 4'd8;  // accumulate
   localparam logic [3:0] OP_MRD     = 4'd9;  // read heads of A and B
   localparam logic [3:0] OP_MSTEP   = 4'd10; // choose term, advance

   typedef struct packed {
      logic [3:0] op;
      logic       tbl;   // 0 A, 1 B
      logic       init;  // restart counters
   } cmd_type;

   typedef struct packed {
      logic sort_pair;   // current pair i, j lies inside the table
      logic sort_more;   // more pairs to compare
      logic eval_more;   // more terms of A
      logic pw_more;     // power needs more steps
      logic merge_more;  // any terms left in A or B
      logic merge_emit;  // current merge step produces a term
      logic any_emitted;
   } stat_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sd2147483647) r = 32'sh7fffffff;
      else if (v < -66'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction
endpackage

[rtl/core/spa_datapath.sv]
// Datapath: term tables, sort compare, power and accumulate unit, merge walk.
module spa_datapath import spa_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   input  logic signed [31:0]  term_coefficient,
   input  logic [5:0]          term_exponent,
   input  logic signed [31:0]  point,
   output stat_type            stat,
   output logic                full,
   output logic signed [31:0]  value,
   output logic signed [31:0]  sum_coefficient,
   output logic [5:0]          sum_exponent
);
   logic signed [31:0] a_co [MaxTerms];
   logic [5:0]         a_ex [MaxTerms];
   logic signed [31:0] b_co [MaxTerms];
   logic [5:0]         b_ex [MaxTerms];
   logic [CntW-1:0] a_count_ff, b_count_ff;
   logic [CntW-1:0] i_ff, j_ff;          // sort indices, also eval and merge A index
   logic [CntW-1:0] q_ff;                // merge B index
   logic signed [31:0] ci_ff, cj_ff;     // read data / merge head coefficients
   logic [5:0]         ei_ff, ej_ff;
   logic signed [31:0] pw_ff, acc_ff, term_ff;
   logic signed [31:0] point_ff;         // evaluation point held for the request
   logic [5:0]         e_ff;             // power steps done
   logic               emitted_ff;
   logic signed [31:0] out_co_ff;
   logic [5:0]         out_ex_ff;

   logic [CntW-1:0] cnt_sel;
   logic signed [63:0] prod;
   logic signed [31:0] mul_a, mul_b;
   logic signed [31:0] msum;
   logic a_left, b_left;

   assign cnt_sel = cmd.tbl ? b_count_ff : a_count_ff;
   assign full    = cnt_sel >= CntW'(MaxTerms);
   assign a_left  = i_ff < a_count_ff;
   assign b_left  = q_ff < b_count_ff;
   assign msum    = sat32(66'(ci_ff) + 66'(cj_ff));

   // Shared multiplier: power step or coefficient times power.
   always_comb begin
      mul_a = pw_ff;
      mul_b = (cmd.op == OP_EPW) ? point_ff : ci_ff;
      prod  = mul_a * mul_b;
   end

   // Status for the controller.
   always_comb begin
      stat.sort_pair   = j_ff < cnt_sel;
      stat.sort_more   = (j_ff + 1'b1) < cnt_sel || (i_ff + 2'd2) < cnt_sel;
      stat.eval_more   = i_ff < a_count_ff;
      stat.pw_more     = e_ff < ei_ff;
      stat.merge_more  = a_left || b_left;
      stat.merge_emit  = !(a_left && b_left && ei_ff == ej_ff && msum == 32'sd0);
      stat.any_emitted = emitted_ff;
   end

   // Table storage.
   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD && !full) begin
         if (cmd.tbl) begin
            b_co[b_count_ff[IdxW-1:0]] <= term_coefficient;
            b_ex[b_count_ff[IdxW-1:0]] <= term_exponent;
         end else begin
            a_co[a_count_ff[IdxW-1:0]] <= term_coefficient;
            a_ex[a_count_ff[IdxW-1:0]] <= term_exponent;
         end
      end
      if (cmd.op == OP_SCMP && ei_ff < ej_ff) begin
         if (cmd.tbl) begin
            b_co[i_ff[IdxW-1:0]] <= cj_ff; b_ex[i_ff[IdxW-1:0]] <= ej_ff;
            b_co[j_ff[IdxW-1:0]] <= ci_ff; b_ex[j_ff[IdxW-1:0]] <= ei_ff;
         end else begin
            a_co[i_ff[IdxW-1:0]] <= cj_ff; a_ex[i_ff[IdxW-1:0]] <= ej_ff;
            a_co[j_ff[IdxW-1:0]] <= ci_ff; a_ex[j_ff[IdxW-1:0]] <= ei_ff;
         end
      end
   end

   // Counts.
   always_ff @(posedge clock) begin
      if (reset || cmd.op == OP_CLEAR) begin
         a_count_ff <= '0;
         b_count_ff <= '0;
      end else if (cmd.op == OP_LOAD && !full) begin
         if (cmd.tbl) b_count_ff <= b_count_ff + 1'b1;
         else         a_count_ff <= a_count_ff + 1'b1;
      end
   end

   // Walk registers.
   always_ff @(posedge clock) begin
      if (cmd.init) begin
         i_ff <= '0; j_ff <= CntW'(1); q_ff <= '0;
         acc_ff <= '0; emitted_ff <= 1'b0;
         point_ff <= point;
      end else begin
         case (cmd.op)
            OP_SRD: begin
               ci_ff <= cmd.tbl ? b_co[i_ff[IdxW-1:0]] : a_co[i_ff[IdxW-1:0]];
               ei_ff <= cmd.tbl ? b_ex[i_ff[IdxW-1:0]] : a_ex[i_ff[IdxW-1:0]];
               cj_ff <= cmd.tbl ? b_co[j_ff[IdxW-1:0]] : a_co[j_ff[IdxW-1:0]];
               ej_ff <= cmd.tbl ? b_ex[j_ff[IdxW-1:0]] : a_ex[j_ff[IdxW-1:0]];
            end
            OP_SCMP: begin
               if ((j_ff + 1'b1) < cnt_sel) j_ff <= j_ff + 1'b1;
               else begin
                  i_ff <= i_ff + 1'b1;
                  j_ff <= i_ff + 2'd2;
               end
            end
            OP_ERD: begin
               ci_ff <= a_co[i_ff[IdxW-1:0]];
               ei_ff <= a_ex[i_ff[IdxW-1:0]];
               pw_ff <= 32'sd1 <<< FractionBits;
               e_ff  <= '0;
            end
            OP_EPW: begin
               pw_ff <= sat32(66'(prod >>> FractionBits));
               e_ff  <= e_ff + 1'b1;
            end
            OP_ETERM: term_ff <= sat32(66'(prod >>> FractionBits));
            OP_EACC: begin
               acc_ff <= sat32(66'(acc_ff) + 66'(term_ff));
               i_ff   <= i_ff + 1'b1;
            end
            OP_MRD: begin
               ci_ff <= a_co[i_ff[IdxW-1:0]];
               ei_ff <= a_ex[i_ff[IdxW-1:0]];
               cj_ff <= b_co[q_ff[IdxW-1:0]];
               ej_ff <= b_ex[q_ff[IdxW-1:0]];
            end
            OP_MSTEP: begin
               if (a_left && (!b_left || ei_ff > ej_ff)) begin
                  out_co_ff <= ci_ff; out_ex_ff <= ei_ff;
                  i_ff <= i_ff + 1'b1;
               end else if (b_left && (!a_left || ei_ff < ej_ff)) begin
                  out_co_ff <= cj_ff; out_ex_ff <= ej_ff;
                  q_ff <= q_ff + 1'b1;
               end else begin
                  // Equal exponents: a zero sum leaves the output term untouched.
                  if (msum != 32'sd0) begin
                     out_co_ff <= msum; out_ex_ff <= ei_ff;
                  end
                  i_ff <= i_ff + 1'b1;
                  q_ff <= q_ff + 1'b1;
               end
               if (stat.merge_emit) emitted_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   assign value           = acc_ff;
   assign sum_coefficient = out_co_ff;
   assign sum_exponent    = out_ex_ff;
endmodule

[rtl/core/spa_control.sv]
// Controller: sequences each request and drives the response register.
module spa_control import spa_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [2:0]         command,
   input  logic               last_term,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic               rsp_final,
   output logic [1:0]         rsp_status,
   output logic               rsp_kind,      // 1 value, 0 sum term
   output logic               rsp_term,      // sum term fields valid
   output cmd_type            cmd,
   input  stat_type           stat,
   input  logic               full
);
   localparam logic [3:0] S_IDLE = 4'd0, S_SRD = 4'd1, S_SCMP = 4'd2, S_ERD = 4'd3,
      S_EPW = 4'd4, S_ETERM = 4'd5, S_EACC = 4'd6, S_MRD = 4'd7, S_MSTEP = 4'd8,
      S_LRSP = 4'd11;

   logic [3:0] state_ff, state_in;
   logic tbl_ff, tbl_in, valid_ff, valid_in, final_ff, final_in;
   logic [1:0] status_ff, status_in;
   logic kind_ff, kind_in, term_ff, term_in;
   logic pend_ff, pend_in;   // merge has a buffered term that is not yet marked final

   assign req_tready = !reset && state_ff == S_IDLE && !valid_ff;
   assign rsp_tvalid = valid_ff;
   assign rsp_final  = final_ff;
   assign rsp_status = status_ff;
   assign rsp_kind   = kind_ff;
   assign rsp_term   = term_ff;

   always_comb begin
      state_in = state_ff; tbl_in = tbl_ff; valid_in = valid_ff;
      final_in = final_ff; status_in = status_ff; kind_in = kind_ff;
      term_in = term_ff; pend_in = pend_ff;
      cmd = '{op: OP_NONE, tbl: tbl_ff, init: 1'b0};
      if (valid_ff && rsp_tready) valid_in = 1'b0;
      case (state_ff)
         S_IDLE: if (req_tvalid && req_tready) begin
            tbl_in = command[0];
            cmd.tbl = command[0];
            case (command)
               CMD_LOAD_A, CMD_LOAD_B: begin
                  cmd.op = OP_LOAD;
                  status_in = full ? ST_FULL : ST_OK;
                  kind_in = 1'b0; term_in = 1'b0; final_in = 1'b1;
                  if (last_term) begin
                     cmd.init = 1'b1;
                     state_in = S_LRSP;
                  end else valid_in = 1'b1;
               end
               CMD_CLEAR: cmd.op = OP_CLEAR;
               CMD_EVAL: begin
                  cmd.init = 1'b1;
                  state_in = S_ERD;
               end
               CMD_ADD: begin
                  cmd.init = 1'b1; pend_in = 1'b0;
                  state_in = S_MRD;
               end
               default: ;
            endcase
         end
         // Load with last term: sort when the table holds a pair, then answer.
         S_LRSP: begin
            if (stat.sort_pair) state_in = S_SRD;
            else begin
               state_in = S_IDLE; valid_in = 1'b1;
            end
         end
         S_SRD: begin
            cmd.op = OP_SRD;
            state_in = S_SCMP;
         end
         S_SCMP: begin
            cmd.op = OP_SCMP;
            state_in = stat.sort_more ? S_SRD : S_IDLE;
            if (!stat.sort_more) valid_in = 1'b1;
         end
         // Evaluate: one power step per cycle, then multiply and accumulate.
         S_ERD: begin
            if (stat.eval_more) begin
               cmd.op = OP_ERD; state_in = S_EPW;
            end else begin
               kind_in = 1'b1; term_in = 1'b0; final_in = 1'b1; status_in = ST_OK;
               valid_in = 1'b1; state_in = S_IDLE;
            end
         end
         S_EPW: if (stat.pw_more) cmd.op = OP_EPW; else state_in = S_ETERM;
         S_ETERM: begin cmd.op = OP_ETERM; state_in = S_EACC; end
         S_EACC: begin cmd.op = OP_EACC; state_in = S_ERD; end
         // Merge: read both heads, then take one step.
         S_MRD: begin
            if (stat.merge_more) begin
               cmd.op = OP_MRD; state_in = S_MSTEP;
            end else if (pend_ff) begin
               // Buffered term is the last one.
               if (!valid_ff) begin
                  kind_in = 1'b0; term_in = 1'b1; final_in = 1'b1; status_in = ST_OK;
                  valid_in = 1'b1; pend_in = 1'b0; state_in = S_IDLE;
               end
            end else begin
               kind_in = 1'b0; term_in = 1'b0; final_in = 1'b1; status_in = ST_EMPTY;
               valid_in = 1'b1; state_in = S_IDLE;
            end
         end
         S_MSTEP: begin
            if (stat.merge_emit && pend_ff) begin
               // Another term follows, so the buffered one goes out as not final.
               if (!valid_ff) begin
                  kind_in = 1'b0; term_in = 1'b1; final_in = 1'b0; status_in = ST_OK;
                  valid_in = 1'b1; pend_in = 1'b0;
               end
            end else if (!(stat.merge_emit && valid_ff)) begin
               // A new term is written only once the previous one has left.
               cmd.op = OP_MSTEP;
               if (stat.merge_emit) pend_in = 1'b1;
               state_in = S_MRD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; valid_ff <= 1'b0; pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in; valid_ff <= valid_in; pend_ff <= pend_in;
      end
      tbl_ff <= tbl_in; final_ff <= final_in; status_ff <= status_in;
      kind_ff <= kind_in; term_ff <= term_in;
   end
endmodule

[rtl/core/sparse_polynomial_add_eval.sv]
// Top level of the sparse polynomial adder and evaluator.
// A load answers in the cycle after it is accepted, or after the exchange sort when it
// carries the last term. Evaluate takes each term of A through a read, its power steps,
// a multiply and an accumulate on the one shared multiplier. Add alternates a head read
// and a merge step, then hands off the response. One request is handled at a time;
// clear answers nothing. Status 1 marks a dropped load into a full table.
module sparse_polynomial_add_eval import spa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // term_coefficient[31:0], term_exponent[37:32],
                                    // point[69:38], zeros
   input  logic [2:0]  req_tuser,   // command[2:0]
   input  logic        req_tlast,   // last_term
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // value[31:0], sum_coefficient[63:32],
                                    // sum_exponent[69:64], zeros
   output logic [1:0]  rsp_tuser,   // status[1:0]
   output logic        rsp_tlast    // final_res
);
   `include "sparse_polynomial_add_eval_defines.svh"
   cmd_type cmd;
   stat_type stat;
   logic full, kind, term_v, fin;
   logic [1:0] status;
   logic signed [31:0] value, sco;
   logic [5:0] sex;

   spa_control u_ctl (.clock, .reset, .req_tvalid, .req_tready,
      .command(req_tuser), .last_term(req_tlast), .rsp_tvalid, .rsp_tready,
      .rsp_final(fin), .rsp_status(status), .rsp_kind(kind), .rsp_term(term_v),
      .cmd, .stat, .full);

   spa_datapath u_dp (.clock, .reset, .cmd,
      .term_coefficient(req_tdata[31:0]), .term_exponent(req_tdata[37:32]),
      .point(req_tdata[69:38]), .stat, .full, .value, .sum_coefficient(sco),
      .sum_exponent(sex));

   assign rsp_tdata = {2'b00, term_v ? sex : 6'd0, term_v ? sco : 32'd0,
                       kind ? value : 32'd0};
   assign rsp_tuser = status;
   assign rsp_tlast = fin;

   `SPA_ASSERT_IMP(a_ready_idle, clock, reset, rsp_tvalid, !req_tready, "ready while held")
   `SPA_ASSERT_IMP(a_kind_excl, clock, reset, rsp_tvalid, !(kind && term_v), "value and term")
   `SPA_ASSERT_IMP(a_empty_final, clock, reset, rsp_tvalid && status == ST_EMPTY, rsp_tlast, "empty")
endmodule
